>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the box grid tiler. Each use names
// its label, its property and its message. The clock and reset are taken
// from the module that uses the macro (clk and rst).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define BGT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define BGT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/bgt_pkg.sv
// ----------------------------------------------------------------------------
// Box grid tiler package
// Field widths, register codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bgt_pkg;

  // Fixed widths of the ports and configuration registers.
  localparam int FIELD_W   = 32;
  localparam int TS_W      = 21;
  localparam int LIMIT_W   = 6;
  localparam int CFG_IDX_W = 2;

  // Register values after reset.
  localparam logic [TS_W-1:0]    TILE_SIZE_RESET = 21'd32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 6'd63;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE = 2'd0,
    CFG_CLIP      = 2'd1,
    CFG_LIMIT     = 2'd2
  } cfg_idx_t;

  // Grid register picked for one rounding step.
  typedef enum logic [1:0] {
    GRID_CURSOR_X = 2'd0,
    GRID_LOW_Y    = 2'd1,
    GRID_HIGH_X   = 2'd2,
    GRID_HIGH_Y   = 2'd3
  } grid_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      capture;
    logic      div_start;
    logic      grid_write;
    grid_sel_t grid_sel;
    logic      run_init;
    logic      emit;
    logic      emit_empty;
  } bgt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic range_empty;
    logic out_free;
    logic tile_last;
  } bgt_status_t;

endpackage

`default_nettype wire

>>> rtl/core/bgt_rem_unit.sv
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring division of an unsigned magnitude by the tile size, four quotient
// bits per cycle, keeping the remainder only.
// ----------------------------------------------------------------------------
`default_nettype none

module bgt_rem_unit
  import bgt_pkg::*;
#(
  parameter int MAG_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] magnitude,
  input  wire logic [TS_W-1:0]  divisor,
  output logic                  busy,
  output logic [TS_W-1:0]       remainder
);

  localparam int STEPS   = 4;
  localparam int CYCLES  = (MAG_W + STEPS - 1) / STEPS;
  localparam int SHIFT_W = CYCLES * STEPS;
  localparam int CNT_W   = $clog2(CYCLES + 1);

  logic [SHIFT_W-1:0] shift;
  logic [TS_W-1:0]    rem;
  logic [TS_W-1:0]    rem_next;
  logic [CNT_W-1:0]   cnt;
  logic [TS_W:0]      trial;

  // Four compare and subtract steps on the top bits of the dividend.
  always_comb begin
    rem_next = rem;
    trial    = '0;
    for (int i = 0; i < STEPS; i++) begin
      trial = {rem_next, shift[SHIFT_W-1-i]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      rem_next = trial[TS_W-1:0];
    end
  end

  // Iteration counter and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      shift <= SHIFT_W'(magnitude);
      rem   <= '0;
      cnt   <= CNT_W'(CYCLES);
    end else if (cnt != '0) begin
      shift <= shift << STEPS;
      rem   <= rem_next;
      cnt   <= cnt - CNT_W'(1);
    end
  end

  assign busy      = (cnt != '0);
  assign remainder = rem;

endmodule

`default_nettype wire

>>> rtl/core/bgt_datapath.sv
// ----------------------------------------------------------------------------
// Box grid tiler datapath
// Configuration registers, the held box, grid rounding through the remainder
// unit, the tile cursor, clipping, the child count and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bgt_datapath
  import bgt_pkg::*;
#(
  parameter int COORD_W   = 32,
  parameter int CHILD_CAP = 63
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TS_W-1:0]      cfg_data,
  input  wire logic [FIELD_W-1:0]   box_min_x,
  input  wire logic [FIELD_W-1:0]   box_min_y,
  input  wire logic [FIELD_W-1:0]   box_max_x,
  input  wire logic [FIELD_W-1:0]   box_max_y,
  input  wire bgt_cmd_t             cmd,
  output bgt_status_t               status,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FIELD_W-1:0]        tile_min_x,
  output logic [FIELD_W-1:0]        tile_min_y,
  output logic [FIELD_W-1:0]        tile_max_x,
  output logic [FIELD_W-1:0]        tile_max_y,
  output logic                      last_tile,
  output logic                      limit_failed,
  output logic                      no_tiles
);

  localparam int GRID_W = ((COORD_W > TS_W) ? COORD_W : TS_W) + 2;
  localparam int CNT_W  = $clog2(CHILD_CAP + 2);

  // Configuration registers.
  logic [TS_W-1:0]    tile_size;
  logic               clip_to_box;
  logic [LIMIT_W-1:0] child_limit;

  // Held box corners, cut to the coordinate width.
  logic [COORD_W-1:0] held_min_x;
  logic [COORD_W-1:0] held_min_y;
  logic [COORD_W-1:0] held_max_x;
  logic [COORD_W-1:0] held_max_y;

  // Grid registers of the current run.
  logic signed [GRID_W-1:0] cursor_x;
  logic signed [GRID_W-1:0] cursor_y;
  logic signed [GRID_W-1:0] grid_low_y;
  logic signed [GRID_W-1:0] grid_high_x;
  logic signed [GRID_W-1:0] grid_high_y;
  logic [CNT_W-1:0]         emitted_count;

  logic [TS_W-1:0]          ts_eff;
  logic [LIMIT_W-1:0]       limit;
  logic signed [GRID_W-1:0] ts_g;
  logic signed [GRID_W-1:0] bx0_g;
  logic signed [GRID_W-1:0] by0_g;
  logic signed [GRID_W-1:0] bx1_g;
  logic signed [GRID_W-1:0] by1_g;

  logic signed [GRID_W-1:0] op_v;
  logic signed [GRID_W-1:0] op_abs;
  logic                     op_neg;
  logic                     div_busy;
  logic [TS_W-1:0]          rem;
  logic [TS_W-1:0]          ts_minus_rem;
  logic [TS_W-1:0]          mod_down;
  logic [TS_W-1:0]          mod_up;
  logic signed [GRID_W-1:0] grid_value;

  logic signed [GRID_W-1:0] x_end;
  logic signed [GRID_W-1:0] y_end;
  logic                     col_done;
  logic                     row_done;
  logic signed [GRID_W-1:0] tx0;
  logic signed [GRID_W-1:0] ty0;
  logic signed [GRID_W-1:0] tx1;
  logic signed [GRID_W-1:0] ty1;
  logic [CNT_W-1:0]         count_next;
  logic                     failed;
  logic                     tile_last;
  logic                     out_free;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size   <= TILE_SIZE_RESET;
      clip_to_box <= 1'b0;
      child_limit <= LIMIT_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        CFG_TILE_SIZE: tile_size   <= cfg_data;
        CFG_CLIP:      clip_to_box <= cfg_data[0];
        CFG_LIMIT:     child_limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero tile size behaves as one; the limit is capped.
  assign ts_eff = (tile_size == '0) ? TS_W'(1) : tile_size;
  assign limit  = (child_limit < LIMIT_W'(CHILD_CAP)) ? child_limit : LIMIT_W'(CHILD_CAP);
  assign ts_g   = GRID_W'(ts_eff);

  assign bx0_g = GRID_W'($signed(held_min_x));
  assign by0_g = GRID_W'($signed(held_min_y));
  assign bx1_g = GRID_W'($signed(held_max_x));
  assign by1_g = GRID_W'($signed(held_max_y));

  // Operand of the rounding step and its magnitude.
  always_comb begin
    unique case (cmd.grid_sel)
      GRID_CURSOR_X: op_v = bx0_g;
      GRID_LOW_Y:    op_v = by0_g;
      GRID_HIGH_X:   op_v = bx1_g;
      GRID_HIGH_Y:   op_v = by1_g;
    endcase
  end

  assign op_neg = op_v[GRID_W-1];
  assign op_abs = op_neg ? -op_v : op_v;

  bgt_rem_unit #(
    .MAG_W(COORD_W)
  ) u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .magnitude (op_abs[COORD_W-1:0]),
    .divisor   (ts_eff),
    .busy      (div_busy),
    .remainder (rem)
  );

  // Round down subtracts the non-negative remainder; round up adds the rest
  // of the tile, or nothing when the value already sits on the grid.
  assign ts_minus_rem = ts_eff - rem;
  assign mod_down     = (op_neg && (rem != '0)) ? ts_minus_rem : rem;
  assign mod_up       = op_neg ? rem : ((rem != '0) ? ts_minus_rem : '0);
  assign grid_value   = ((cmd.grid_sel == GRID_HIGH_X) || (cmd.grid_sel == GRID_HIGH_Y))
                        ? (op_v + GRID_W'(mod_up)) : (op_v - GRID_W'(mod_down));

  // Current tile, its clipped corners and the end of run tests.
  assign x_end    = cursor_x + ts_g;
  assign y_end    = cursor_y + ts_g;
  assign col_done = (x_end >= grid_high_x);
  assign row_done = (y_end >= grid_high_y);
  assign tx0 = (clip_to_box && (bx0_g > cursor_x)) ? bx0_g : cursor_x;
  assign ty0 = (clip_to_box && (by0_g > cursor_y)) ? by0_g : cursor_y;
  assign tx1 = (clip_to_box && (bx1_g < x_end)) ? bx1_g : x_end;
  assign ty1 = (clip_to_box && (by1_g < y_end)) ? by1_g : y_end;

  assign count_next = emitted_count + CNT_W'(1);
  assign failed     = (count_next > CNT_W'(limit));
  assign tile_last  = failed || (col_done && row_done);
  assign out_free   = !out_valid || !out_stall;

  // Held box, grid registers and tile cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
    end else begin
      if (cmd.run_init) begin
        emitted_count <= '0;
      end else if (cmd.emit) begin
        emitted_count <= count_next;
      end
    end

    if (cmd.capture) begin
      held_min_x <= box_min_x[COORD_W-1:0];
      held_min_y <= box_min_y[COORD_W-1:0];
      held_max_x <= box_max_x[COORD_W-1:0];
      held_max_y <= box_max_y[COORD_W-1:0];
    end

    if (cmd.grid_write) begin
      unique case (cmd.grid_sel)
        GRID_CURSOR_X: cursor_x    <= grid_value;
        GRID_LOW_Y:    grid_low_y  <= grid_value;
        GRID_HIGH_X:   grid_high_x <= grid_value;
        GRID_HIGH_Y:   grid_high_y <= grid_value;
      endcase
    end

    if (cmd.run_init) begin
      cursor_y <= grid_low_y;
    end else if (cmd.emit) begin
      if (row_done) begin
        cursor_y <= grid_low_y;
        cursor_x <= x_end;
      end else begin
        cursor_y <= y_end;
      end
    end
  end

  // Output register; the coordinates wrap to the coordinate width.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end

    if (cmd.emit) begin
      tile_min_x   <= FIELD_W'($signed(tx0[COORD_W-1:0]));
      tile_min_y   <= FIELD_W'($signed(ty0[COORD_W-1:0]));
      tile_max_x   <= FIELD_W'($signed(tx1[COORD_W-1:0]));
      tile_max_y   <= FIELD_W'($signed(ty1[COORD_W-1:0]));
      last_tile    <= tile_last;
      limit_failed <= failed;
      no_tiles     <= 1'b0;
    end else if (cmd.emit_empty) begin
      tile_min_x   <= '0;
      tile_min_y   <= '0;
      tile_max_x   <= '0;
      tile_max_y   <= '0;
      last_tile    <= 1'b1;
      limit_failed <= 1'b0;
      no_tiles     <= 1'b1;
    end
  end

  always_comb begin
    status.div_busy    = div_busy;
    status.range_empty = (cursor_x >= grid_high_x) || (grid_low_y >= grid_high_y);
    status.out_free    = out_free;
    status.tile_last   = tile_last;
  end

  // A result is only loaded into a free output register.
  `BGT_ASSERT(a_load_into_free, (cmd.emit || cmd.emit_empty) |-> out_free, "output overwritten")
  // A failed run always ends on the result that reports it.
  `BGT_ASSERT(a_fail_is_last, out_valid && limit_failed |-> last_tile, "fail without last")
  // A tile is only emitted while the child count is within the limit.
  `BGT_ASSERT(a_count_bound, cmd.emit |-> emitted_count <= CNT_W'(limit), "count overrun")

endmodule

`default_nettype wire

>>> rtl/core/bgt_ctrl.sv
// ----------------------------------------------------------------------------
// Box grid tiler controller
// Sequences the capture of a box, the four grid rounding steps and the
// emission of tiles, one per cycle while the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bgt_ctrl
  import bgt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire bgt_status_t status,
  output bgt_cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_START,
    S_DIV_WAIT,
    S_GRID,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t    state;
  grid_sel_t grid_sel;

  // State register and the rounding step index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      grid_sel <= GRID_CURSOR_X;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            grid_sel <= GRID_CURSOR_X;
            state    <= S_DIV_START;
          end
        end
        S_DIV_START: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (!status.div_busy) begin
            state <= S_GRID;
          end
        end
        S_GRID: begin
          if (grid_sel == GRID_HIGH_Y) begin
            state <= S_CHECK;
          end else begin
            grid_sel <= grid_sel_t'(grid_sel + 2'd1);
            state    <= S_DIV_START;
          end
        end
        S_CHECK: begin
          if (!status.range_empty) begin
            state <= S_EMIT;
          end else if (status.out_free) begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (status.out_free && status.tile_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Command decode.
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.capture    = in_valid && (state == S_IDLE);
    cmd.div_start  = (state == S_DIV_START);
    cmd.grid_write = (state == S_GRID);
    cmd.grid_sel   = grid_sel;
    cmd.run_init   = (state == S_CHECK) && !status.range_empty;
    cmd.emit_empty = (state == S_CHECK) && status.range_empty && status.out_free;
    cmd.emit       = (state == S_EMIT) && status.out_free;
  end

  // The controller leaves reset idle.
  `BGT_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE, "not idle after reset")
  // A division is started only on an idle remainder unit.
  `BGT_ASSERT(a_div_idle, cmd.div_start |-> !status.div_busy, "divider restarted")
  // The last tile of a run returns the controller to idle.
  `BGT_ASSERT(a_last_idle, cmd.emit && status.tile_last |=> state == S_IDLE, "run did not end")

endmodule

`default_nettype wire

>>> rtl/core/box_grid_tiler_top.sv
// ----------------------------------------------------------------------------
// Box grid tiler
// Rounds one box per item out to the tile grid and emits every covering
// tile, X outer and Y inner, optionally clipped, with a child limit.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                     Payload
//   input     in_valid / in_stall           box_min_x, box_min_y, box_max_x, box_max_y
//   output    out_valid / out_stall         tile_*, last_tile, limit_failed, no_tiles
//   config    cfg_write_en (no wait)        cfg_index, cfg_data
//
// Before its first result an item passes the four grid roundings, each a start,
// a wait on the remainder unit and a grid write, and then the range check,
// which itself writes the result for a box that covers no tiles; then one
// tile per cycle follows while the output is not stalled.
// The four grid roundings share the one remainder unit, one after another.
// Reset is synchronous and active high and sets the registers to 32, 0, 63.
// A stalled result holds in the output register; tile emission waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module box_grid_tiler_top
  import bgt_pkg::*;
#(
  parameter int CHILD_CAP   = 63,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TS_W-1:0]      cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [FIELD_W-1:0]   box_min_x,
  input  wire logic [FIELD_W-1:0]   box_min_y,
  input  wire logic [FIELD_W-1:0]   box_max_x,
  input  wire logic [FIELD_W-1:0]   box_max_y,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [FIELD_W-1:0]        tile_min_x,
  output logic [FIELD_W-1:0]        tile_min_y,
  output logic [FIELD_W-1:0]        tile_max_x,
  output logic [FIELD_W-1:0]        tile_max_y,
  output logic                      last_tile,
  output logic                      limit_failed,
  output logic                      no_tiles
);

  bgt_cmd_t    cmd;
  bgt_status_t status;

  // Sequencer.
  bgt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic, grid registers and output register.
  bgt_datapath #(
    .COORD_W   (COORD_WIDTH),
    .CHILD_CAP (CHILD_CAP)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .box_min_x    (box_min_x),
    .box_min_y    (box_min_y),
    .box_max_x    (box_max_x),
    .box_max_y    (box_max_y),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .tile_min_x   (tile_min_x),
    .tile_min_y   (tile_min_y),
    .tile_max_x   (tile_max_x),
    .tile_max_y   (tile_max_y),
    .last_tile    (last_tile),
    .limit_failed (limit_failed),
    .no_tiles     (no_tiles)
  );

endmodule

`default_nettype wire
